// ===== sv/sgt_pkg.sv =====
// Shared types, widths and codes of the squelch gate timing block.
`default_nettype none

package sgt_pkg;

    // Sample time and advance count widths
    localparam int TIME_BITS  = 24;
    localparam int COUNT_BITS = 16;
    localparam int CFG_BITS   = TIME_BITS + 1;
    localparam int CFG_IDX_BITS = 3;

    // Item kinds
    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_DETECT  = 1'b1;

    // Report causes
    localparam logic CAUSE_DETECT  = 1'b0;
    localparam logic CAUSE_TIMEOUT = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_OPEN_DELAY   = 3'd0,
        CFG_START_DELAY  = 3'd1,
        CFG_OPEN_TIMEOUT = 3'd2,
        CFG_HANG         = 3'd3,
        CFG_EXT_HANG     = 3'd4,
        CFG_USE_EXT_HANG = 3'd5
    } t_sgt_cfg_idx;

    // Configuration as seen by the timing logic
    typedef struct packed {
        logic [TIME_BITS-1:0] open_delay;
        logic [CFG_BITS-1:0]  open_timeout;
        logic [TIME_BITS-1:0] hang;
        logic [TIME_BITS-1:0] ext_hang;
        logic                 use_ext_hang;
    } t_sgt_cfg;

    // Start delay reload from a configuration write
    typedef struct packed {
        logic                 load;
        logic [TIME_BITS-1:0] value;
    } t_sgt_start_ld;

    // Gate timing state; the timeout timer is off when to_on is low
    typedef struct packed {
        logic                 open;
        logic                 det;
        logic [TIME_BITS-1:0] delay_left;
        logic [TIME_BITS-1:0] hang_left;
        logic                 to_on;
        logic [TIME_BITS-1:0] to_left;
        logic [TIME_BITS-1:0] start_left;
    } t_sgt_state;

    // Report issued by one item
    typedef struct packed {
        logic valid;
        logic open;
        logic cause;
    } t_sgt_rep;

    // Working copy of state and report while an item is evaluated
    typedef struct packed {
        t_sgt_state st;
        t_sgt_rep   rep;
    } t_sgt_work;

endpackage

`default_nettype wire

// ===== sv/sgt_cfg_regs.sv =====
// Configuration register file of the squelch gate timing block.
`default_nettype none

module sgt_cfg_regs
    import sgt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_wr,
    input  wire logic [CFG_IDX_BITS-1:0] i_index,
    input  wire logic [CFG_BITS-1:0]     i_data,
    output t_sgt_cfg                     o_cfg,
    output t_sgt_start_ld                o_start_ld
);

    t_sgt_cfg r_cfg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_delay   <= '0;
            r_cfg.open_timeout <= '1;
            r_cfg.hang         <= '0;
            r_cfg.ext_hang     <= '0;
            r_cfg.use_ext_hang <= 1'b0;
        end else if (i_wr) begin
            case (t_sgt_cfg_idx'(i_index))
                CFG_OPEN_DELAY:   r_cfg.open_delay   <= i_data[TIME_BITS-1:0];
                CFG_OPEN_TIMEOUT: r_cfg.open_timeout <= i_data;
                CFG_HANG:         r_cfg.hang         <= i_data[TIME_BITS-1:0];
                CFG_EXT_HANG:     r_cfg.ext_hang     <= i_data[TIME_BITS-1:0];
                CFG_USE_EXT_HANG: r_cfg.use_ext_hang <= i_data[0];
                default: ;
            endcase
        end
    end

    // Start delay is not kept: a write reloads the running start counter
    assign o_start_ld.load  = i_wr && (t_sgt_cfg_idx'(i_index) == CFG_START_DELAY);
    assign o_start_ld.value = i_data[TIME_BITS-1:0];
    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/sgt_step.sv =====
// Next-state and report logic for one item of the squelch gate timing block.
`default_nettype none

module sgt_step
    import sgt_pkg::*;
(
    input  wire t_sgt_state              i_state,
    input  wire t_sgt_cfg                i_cfg,
    input  wire logic                    i_command,
    input  wire logic [COUNT_BITS-1:0]   i_sample_count,
    input  wire logic                    i_detected,
    output t_sgt_state                   o_state,
    output t_sgt_rep                     o_rep
);

    // Change the gate, reload an enabled timeout on opening, and report unless timed out at once
    function automatic t_sgt_work set_gate(t_sgt_work w_in, logic o, t_sgt_cfg cfg);
        t_sgt_work w;
        w = w_in;
        if (o != w.st.open) begin
            w.st.open = o;
            if (o && !cfg.open_timeout[CFG_BITS-1]) begin
                w.st.to_on   = 1'b1;
                w.st.to_left = cfg.open_timeout[TIME_BITS-1:0];
            end else begin
                w.st.to_on = 1'b0;
            end
            if (!(w.st.to_on && (w.st.to_left == '0))) begin
                w.rep.valid = 1'b1;
                w.rep.open  = o;
                w.rep.cause = CAUSE_DETECT;
            end
        end
        return w;
    endfunction

    // Record a detector level and start the open delay or hangtime
    function automatic t_sgt_work apply_level(t_sgt_work w_in, logic det, t_sgt_cfg cfg);
        t_sgt_work            w;
        logic [TIME_BITS-1:0] hsel;
        w = w_in;
        hsel = cfg.use_ext_hang ? cfg.ext_hang : cfg.hang;
        w.st.det = det;
        if (w.st.start_left == '0) begin
            if (det) begin
                w.st.hang_left = '0;
                if (!w.st.open && (w.st.delay_left == '0)) begin
                    if (cfg.open_delay == '0) begin
                        w = set_gate(w, 1'b1, cfg);
                    end else begin
                        w.st.delay_left = cfg.open_delay;
                    end
                end
            end else begin
                w.st.delay_left = '0;
                if (w.st.open && (w.st.hang_left == '0)) begin
                    if (hsel == '0) begin
                        w = set_gate(w, 1'b0, cfg);
                    end else begin
                        w.st.hang_left = hsel;
                    end
                end
            end
        end
        return w;
    endfunction

    t_sgt_work            w;
    logic [TIME_BITS-1:0] cnt;
    logic                 held;

    // Evaluate one item against the current state
    always_comb begin
        w.st  = i_state;
        w.rep = '0;
        cnt   = TIME_BITS'(i_sample_count);
        held  = 1'b0;
        if (i_command == CMD_DETECT) begin
            w = apply_level(w, i_detected, i_cfg);
        end else begin
            // Run down the open timeout
            if (w.st.to_on && (w.st.to_left != '0)) begin
                if (w.st.to_left <= cnt) begin
                    w.st.to_left = '0;
                    w.rep.valid  = 1'b1;
                    w.rep.open   = 1'b0;
                    w.rep.cause  = CAUSE_TIMEOUT;
                end else begin
                    w.st.to_left = w.st.to_left - cnt;
                end
            end
            // Swallow samples in the start delay, apply the level when it ends
            if (w.st.start_left != '0) begin
                if (cnt < w.st.start_left) begin
                    w.st.start_left = w.st.start_left - cnt;
                    cnt  = '0;
                    held = 1'b1;
                end else begin
                    cnt = cnt - w.st.start_left;
                    w.st.start_left = '0;
                    w = apply_level(w, w.st.det, i_cfg);
                end
            end
            if (!held) begin
                // Open delay
                if (w.st.delay_left != '0) begin
                    if (w.st.delay_left <= cnt) begin
                        w.st.delay_left = '0;
                        w = set_gate(w, 1'b1, i_cfg);
                    end else begin
                        w.st.delay_left = w.st.delay_left - cnt;
                    end
                end
                // Hangtime
                if (w.st.hang_left != '0) begin
                    if (w.st.hang_left <= cnt) begin
                        w.st.hang_left = '0;
                        w = set_gate(w, 1'b0, i_cfg);
                    end else begin
                        w.st.hang_left = w.st.hang_left - cnt;
                    end
                end
            end
        end
    end

    assign o_state = w.st;
    assign o_rep   = w.rep;

endmodule

`default_nettype wire

// ===== sv/squelch_gate_timing.sv =====
// Top level of the squelch gate timing block.
// Input channel (i_valid/o_ready) carries one item: i_command selects an
// advance of i_sample_count samples or a new detector level i_detected.
// Output channel (o_valid/i_ready) returns exactly one result per item: the
// gate state after the item and an optional open or close report with cause.
// Configuration channel (i_cfg_valid/o_cfg_ready) writes register
// i_cfg_index with i_cfg_data; it is always ready. Write only while idle.
// Path: an accepted item waits in the input register, then passes through the
// timing logic into the result register once that register is free or
// draining.
// Throughput: one item per cycle while i_ready keeps results moving; the timing
// state updates in one pass of the logic between the input and result registers.
// Reset: gate closed, all timers idle, timeout off, registers at their
// defaults (open timeout disabled). A start delay write restarts the start
// counter.
// Stall: while a result waits on i_ready the input register still takes an
// item if it is empty; it holds once full until the result moves on.
`default_nettype none

module squelch_gate_timing
    import sgt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // item in
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_command,
    input  wire logic [COUNT_BITS-1:0]   i_sample_count,
    input  wire logic                    i_detected,
    // result out
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic                         o_gate_open,
    output logic                         o_report_valid,
    output logic                         o_report_open,
    output logic                         o_report_cause,
    // configuration
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data
);

    logic                  r_in_v;
    logic                  r_in_cmd;
    logic [COUNT_BITS-1:0] r_in_cnt;
    logic                  r_in_det;

    logic                  r_out_v;
    logic                  r_out_open;
    t_sgt_rep              r_out_rep;

    t_sgt_state            r_state;
    t_sgt_state            n_state;
    t_sgt_rep              n_rep;
    t_sgt_cfg              cfg;
    t_sgt_start_ld         start_ld;
    logic                  adv;

    assign o_cfg_ready = 1'b1;

    sgt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (i_cfg_valid),
        .i_index    (i_cfg_index),
        .i_data     (i_cfg_data),
        .o_cfg      (cfg),
        .o_start_ld (start_ld)
    );

    sgt_step u_step (
        .i_state        (r_state),
        .i_cfg          (cfg),
        .i_command      (r_in_cmd),
        .i_sample_count (r_in_cnt),
        .i_detected     (r_in_det),
        .o_state        (n_state),
        .o_rep          (n_rep)
    );

    // Move the held item on when the result register is free or draining
    assign adv     = r_in_v && (!r_out_v || i_ready);
    assign o_ready = !r_in_v || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_cmd <= i_command;
            r_in_cnt <= i_sample_count;
            r_in_det <= i_detected;
        end
    end

    // Timing state; a start delay write reloads the start counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end else if (start_ld.load) begin
            r_state.start_left <= start_ld.value;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
        if (adv) begin
            r_out_open <= n_state.open;
            r_out_rep  <= n_rep;
        end
    end

    assign o_valid        = r_out_v;
    assign o_gate_open    = r_out_open;
    assign o_report_valid = r_out_rep.valid;
    assign o_report_open  = r_out_rep.open;
    assign o_report_cause = r_out_rep.cause;

endmodule

`default_nettype wire

// ===== verif/squelch_gate_checker.sv =====
// Checker for the squelch gate timing block: mirrors its timing state and compares each result.
module squelch_gate_checker
    import sgt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // item channel
    input  wire logic                    i_item_valid,
    input  wire logic                    i_item_ready,
    input  wire logic                    i_command,
    input  wire logic [COUNT_BITS-1:0]   i_sample_count,
    input  wire logic                    i_detected,
    // result channel
    input  wire logic                    i_res_valid,
    input  wire logic                    i_res_ready,
    input  wire logic                    i_gate_open,
    input  wire logic                    i_report_valid,
    input  wire logic                    i_report_open,
    input  wire logic                    i_report_cause,
    // configuration channel
    input  wire logic                    i_cfg_valid,
    input  wire logic                    i_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data,
    // status to the bench top
    output int                           o_fail_count,
    output int                           o_pending
);

    localparam longint TIMER_OFF    = -1;

    typedef struct packed {
        logic gate_open;
        logic report_valid;
        logic report_open;
        logic report_cause;
    } t_gate_result;

    // Register mirror
    longint open_delay_reg;
    longint start_delay_reg;
    longint open_timeout_reg;
    longint hang_reg;
    longint ext_hang_reg;
    bit     use_ext_reg;

    // Timing state mirror
    bit     gate_q;
    bit     level_q;
    longint delay_left;
    longint hang_left;
    longint timeout_left;
    longint start_left;

    t_gate_result report_q;
    t_gate_result results_due[$];
    int unsigned  results_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        results_seen = 0;
    end

    // Print one line per mismatch and count it
    task automatic note_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic check_field(input string field, input int unsigned seq,
                               input logic got_bit, input logic want_bit);
        if (got_bit !== want_bit)
            note_mismatch($sformatf("result %0d: %s is %b, predicted %b",
                                    seq, field, got_bit, want_bit));
    endtask

    function automatic void restore_defaults();
        open_delay_reg   = 0;
        start_delay_reg  = 0;
        open_timeout_reg = TIMER_OFF;
        hang_reg         = 0;
        ext_hang_reg     = 0;
        use_ext_reg      = 1'b0;
        gate_q           = 1'b0;
        level_q          = 1'b0;
        delay_left       = 0;
        hang_left        = 0;
        timeout_left     = TIMER_OFF;
        start_left       = 0;
    endfunction

    // Mirror a register write; spare indexes are dropped
    function automatic void mirror_write(logic [CFG_IDX_BITS-1:0] idx,
                                         logic [CFG_BITS-1:0] data);
        case (idx)
            CFG_OPEN_DELAY:   open_delay_reg = longint'(data[TIME_BITS-1:0]);
            CFG_START_DELAY: begin
                start_delay_reg = longint'(data[TIME_BITS-1:0]);
                start_left      = start_delay_reg;
            end
            CFG_OPEN_TIMEOUT: open_timeout_reg = longint'($signed(data));
            CFG_HANG:         hang_reg = longint'(data[TIME_BITS-1:0]);
            CFG_EXT_HANG:     ext_hang_reg = longint'(data[TIME_BITS-1:0]);
            CFG_USE_EXT_HANG: use_ext_reg = data[0];
            default: ;
        endcase
    endfunction

    // Later reports in the same item overwrite earlier ones
    function automatic void issue_report(logic lvl, logic cause);
        report_q.report_valid = 1'b1;
        report_q.report_open  = lvl;
        report_q.report_cause = cause;
    endfunction

    function automatic void switch_gate(bit open_now);
        if (open_now != gate_q) begin
            gate_q = open_now;
            if (open_now)
                timeout_left = (open_timeout_reg < 0) ? TIMER_OFF : open_timeout_reg;
            else
                timeout_left = TIMER_OFF;
            // a gate that times out on opening stays silent
            if (timeout_left != 0)
                issue_report(open_now, CAUSE_DETECT);
        end
    endfunction

    function automatic void take_level(bit det);
        longint hang;
        hang    = use_ext_reg ? ext_hang_reg : hang_reg;
        level_q = det;
        if (start_left > 0)
            return;
        if (det) begin
            hang_left = 0;
            if (!gate_q && delay_left <= 0) begin
                if (open_delay_reg == 0)
                    switch_gate(1'b1);
                else
                    delay_left = open_delay_reg;
            end
        end else begin
            delay_left = 0;
            if (gate_q && hang_left <= 0) begin
                if (hang == 0)
                    switch_gate(1'b0);
                else
                    hang_left = hang;
            end
        end
    endfunction

    function automatic void run_samples(longint count);
        longint used;
        // open timeout runs on the full count
        if (timeout_left > 0) begin
            timeout_left -= count;
            if (timeout_left <= 0) begin
                timeout_left = 0;
                issue_report(1'b0, CAUSE_TIMEOUT);
            end
        end
        // start delay eats samples first, the rest goes on
        if (start_left > 0) begin
            used        = (count < start_left) ? count : start_left;
            start_left -= used;
            count      -= used;
            if (start_left > 0)
                return;
            take_level(level_q);
        end
        if (delay_left > 0) begin
            delay_left -= count;
            if (delay_left <= 0) begin
                delay_left = 0;
                switch_gate(1'b1);
            end
        end
        if (hang_left > 0) begin
            hang_left -= count;
            if (hang_left <= 0) begin
                hang_left = 0;
                switch_gate(1'b0);
            end
        end
    endfunction

    function automatic t_gate_result predict_gate(logic cmd, logic [COUNT_BITS-1:0] cnt,
                                                  logic det);
        report_q = '0;
        if (cmd == CMD_DETECT)
            take_level(det);
        else
            run_samples(longint'(cnt));
        report_q.gate_open = gate_q;
        return report_q;
    endfunction

    // Track the channels at each edge
    always @(posedge i_clk) begin
        t_gate_result got;
        t_gate_result want;
        if (!i_rst_n) begin
            restore_defaults();
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                mirror_write(i_cfg_index, i_cfg_data);
            if (i_item_valid && i_item_ready)
                results_due.push_back(predict_gate(i_command, i_sample_count, i_detected));
            if (i_res_valid && i_res_ready) begin
                got = {i_gate_open, i_report_valid, i_report_open, i_report_cause};
                if (results_due.size() == 0) begin
                    note_mismatch($sformatf("result %0d (%b) with no item outstanding",
                                            results_seen, got));
                end else begin
                    want = results_due.pop_front();
                    check_field("gate_open",    results_seen, got.gate_open,
                                want.gate_open);
                    check_field("report_valid", results_seen, got.report_valid,
                                want.report_valid);
                    check_field("report_open",  results_seen, got.report_open,
                                want.report_open);
                    check_field("report_cause", results_seen, got.report_cause,
                                want.report_cause);
                end
                results_seen++;
            end
        end
        o_pending = results_due.size();
    end

endmodule

// ===== verif/squelch_gate_timing_tb.sv =====
// Bench top for the squelch gate timing block: clock, reset, stimulus and verdict.
module squelch_gate_timing_tb;
    import sgt_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int RANDOM_PHASES   = 8;
    localparam int RUN_LIMIT       = 3_000_000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [TIME_BITS-1:0]    TIME_MAX     = '1;
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX    = '1;
    localparam logic [CFG_BITS-1:0]     TIMEOUT_OFF  = '1;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    i_command      = CMD_ADVANCE;
    logic [COUNT_BITS-1:0]   i_sample_count = '0;
    logic                    i_detected     = 1'b0;
    logic                    i_ready        = 1'b0;
    logic                    i_cfg_valid    = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index    = CFG_OPEN_DELAY;
    logic [CFG_BITS-1:0]     i_cfg_data     = '0;

    logic o_ready;
    logic o_valid;
    logic o_gate_open;
    logic o_report_valid;
    logic o_report_open;
    logic o_report_cause;
    logic o_cfg_ready;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_off_req       = 1'b0;
    int fail_count;
    int pending;

    squelch_gate_timing dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_sample_count (i_sample_count),
        .i_detected     (i_detected),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_gate_open    (o_gate_open),
        .o_report_valid (o_report_valid),
        .o_report_open  (o_report_open),
        .o_report_cause (o_report_cause),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    squelch_gate_checker gate_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (i_valid),
        .i_item_ready   (o_ready),
        .i_command      (i_command),
        .i_sample_count (i_sample_count),
        .i_detected     (i_detected),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_gate_open    (o_gate_open),
        .i_report_valid (o_report_valid),
        .i_report_open  (o_report_open),
        .i_report_cause (o_report_cause),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input logic cmd, input logic [COUNT_BITS-1:0] cnt,
                             input logic det);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_sample_count <= cnt;
        i_detected     <= det;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Load all registers, spare indexes too; only call while idle
    task automatic apply_settings(input logic [CFG_BITS-1:0] open_dly,
                                  input logic [CFG_BITS-1:0] start_dly,
                                  input logic [CFG_BITS-1:0] timeout,
                                  input logic [CFG_BITS-1:0] hang,
                                  input logic [CFG_BITS-1:0] ext_hang,
                                  input logic [CFG_BITS-1:0] use_ext);
        write_reg(CFG_SPARE_LO, CFG_BITS'($urandom));
        write_reg(CFG_OPEN_DELAY, open_dly);
        write_reg(CFG_OPEN_TIMEOUT, timeout);
        write_reg(CFG_HANG, hang);
        write_reg(CFG_EXT_HANG, ext_hang);
        write_reg(CFG_USE_EXT_HANG, use_ext);
        write_reg(CFG_START_DELAY, start_dly);
        write_reg(CFG_SPARE_HI, CFG_BITS'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sample time: mostly short so timers expire, with both extremes
    function automatic logic [CFG_BITS-1:0] pick_time();
        int unsigned roll;
        logic [CFG_BITS-1:0] v;
        roll = $urandom_range(99);
        if (roll < 12)
            v[TIME_BITS-1:0] = '0;
        else if (roll < 20)
            v[TIME_BITS-1:0] = TIME_MAX;
        else if (roll < 28)
            v[TIME_BITS-1:0] = TIME_BITS'($urandom);
        else
            v[TIME_BITS-1:0] = TIME_BITS'($urandom_range(1, 1500));
        // top bit is outside the register and must be dropped
        v[TIME_BITS] = 1'($urandom_range(1));
        return v;
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_timeout();
        int unsigned roll;
        logic [CFG_BITS-1:0] v;
        roll = $urandom_range(99);
        v    = pick_time();
        if (roll < 15)
            v = TIMEOUT_OFF;
        else if (roll < 25)
            v[TIME_BITS] = 1'b1;
        else
            v[TIME_BITS] = 1'b0;
        return v;
    endfunction

    // Random item: detect or advance, junk in the unused field
    task automatic send_random_item();
        int unsigned roll;
        logic [COUNT_BITS-1:0] cnt;
        roll = $urandom_range(99);
        if (roll < 40) begin
            send_item(CMD_DETECT, COUNT_BITS'($urandom), 1'($urandom_range(1)));
        end else begin
            roll = $urandom_range(99);
            if (roll < 8)
                cnt = '0;
            else if (roll < 16)
                cnt = COUNT_MAX;
            else if (roll < 30)
                cnt = COUNT_BITS'($urandom);
            else
                cnt = COUNT_BITS'($urandom_range(1, 500));
            send_item(CMD_ADVANCE, cnt, 1'($urandom_range(1)));
        end
    endtask

    // Stimulus
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults: gate follows detection at once, unused fields carry junk
        send_item(CMD_DETECT,  '0,        1'b1);
        send_item(CMD_ADVANCE, '0,        1'b1);
        send_item(CMD_ADVANCE, COUNT_MAX, 1'b0);
        send_item(CMD_DETECT,  COUNT_MAX, 1'b0);
        send_item(CMD_DETECT,  '0,        1'b0);

        // Start delay swallowing samples, open delay, zero timeout, hangtime
        drain();
        apply_settings(CFG_BITS'(5), CFG_BITS'(10), '0, CFG_BITS'(3), CFG_BITS'(7), '0);
        send_item(CMD_DETECT,  '0,             1'b1);
        send_item(CMD_ADVANCE, COUNT_BITS'(4), 1'b0);
        send_item(CMD_ADVANCE, COUNT_BITS'(8), 1'b0);
        send_item(CMD_ADVANCE, COUNT_BITS'(3), 1'b0);
        send_item(CMD_DETECT,  '0,             1'b0);
        send_item(CMD_DETECT,  '0,             1'b1);
        send_item(CMD_DETECT,  '0,             1'b0);
        send_item(CMD_ADVANCE, COUNT_BITS'(5), 1'b0);

        // Timeout close, later close, and timeout plus hang end in one item
        drain();
        apply_settings('0, '0, CFG_BITS'(4), '0, CFG_BITS'(2), CFG_BITS'(1));
        send_item(CMD_DETECT,  '0,              1'b1);
        send_item(CMD_ADVANCE, COUNT_BITS'(10), 1'b0);
        send_item(CMD_DETECT,  '0,              1'b0);
        send_item(CMD_ADVANCE, COUNT_BITS'(2),  1'b0);
        send_item(CMD_DETECT,  '0,              1'b1);
        send_item(CMD_DETECT,  '0,              1'b0);
        send_item(CMD_ADVANCE, COUNT_MAX,       1'b0);

        // Random phases over the idling modes
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
                default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
            endcase
            if (phase == 1)
                apply_settings({1'b1, TIME_MAX}, '0, {1'b0, TIME_MAX}, {1'b1, TIME_MAX},
                               TIME_MAX, CFG_BITS'(1));
            else
                apply_settings(pick_time(),
                               ($urandom_range(3) == 0) ? pick_time() : '0,
                               pick_timeout(), pick_time(), pick_time(),
                               CFG_BITS'($urandom));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold-off while items keep coming
                if (phase == 0 && n == 10)
                    hold_off_req = 1'b1;
                // pause until all results are back, then carry on
                if (phase == 5 && n == 60)
                    drain();
                send_random_item();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
